@@ rtl/mkds_pkg.sv @@
// ----------------------------------------------------------------------------
// mkds_pkg
// Shared types and constants for the keypad debounce scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mkds_pkg;

    // debounce machine phases
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_HELD    = 2'd2,
        PH_GRACE   = 2'd3
    } t_phase;

    // request function codes
    localparam logic FUNC_POLL = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam int unsigned MATRIX_W = 32;
    localparam int unsigned CODE_W   = 12;
    localparam int unsigned VALUE_W  = 7;

    // decoded key value is this base plus 4*row+col
    localparam logic [VALUE_W-1:0] VALUE_BASE = 7'h60;

endpackage : mkds_pkg

`default_nettype wire

@@ rtl/matrix_keypad_debounce_scanner.sv @@
// A request is held in the input register once accepted, and its result in the
// result register, which drives result valid; throughput: one request per cycle
// while the result register is free or being read (i_out_ready), set by the
// single pass of decode and state update between the two registers.
// Reset (synchronous, active low) empties both stages and returns the
// debounce machine to idle with code, value and flags cleared.
// ----------------------------------------------------------------------------
// matrix_keypad_debounce_scanner
// Keypad snapshot scanner with a four-phase debounce machine and a
// clear-on-read key value.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_keypad_debounce_scanner
    import mkds_pkg::*;
#(
    parameter int unsigned ROWS = 8,
    parameter int unsigned COLS = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_func,
    input  wire logic [MATRIX_W-1:0] i_key_matrix,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [VALUE_W-1:0]       o_read_value,
    output logic                     o_key_held,
    output logic                     o_key_pending,
    output logic [1:0]               o_scan_phase
);

    localparam logic [3:0] COL_MASK = 4'((1 << COLS) - 1);

    // input register
    logic                r_s1_valid;
    logic                r_s1_func;
    logic [MATRIX_W-1:0] r_s1_matrix;

    // scanner state
    t_phase              r_phase, n_phase;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [VALUE_W-1:0]  r_latched, n_latched;
    logic                r_held, n_held;
    logic                r_new, n_new;

    // result register
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_out_held;
    logic                r_out_pending;
    logic [1:0]          r_out_phase;

    logic [VALUE_W-1:0]  n_value;
    logic                out_free;
    logic                s1_adv;

    // combinational decode
    logic                any_key;
    logic [CODE_W-1:0]   scan_code;
    logic [3:0]          low_cols;
    logic                same_key;
    logic                dec_ok;
    logic [2:0]          dec_row;
    logic [1:0]          dec_col;
    logic [7:0]          drive_n;
    logic [3:0]          cols_n;
    logic [3:0]          pcols;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;

    always_comb begin
        any_key   = 1'b0;
        scan_code = r_code;
        low_cols  = 4'd0;
        for (int r = 0; r < ROWS; r++) begin
            pcols = r_s1_matrix[r*4 +: 4] & COL_MASK;
            if (pcols != 4'd0) begin
                any_key   = 1'b1;
                // highest pressed row wins
                scan_code = {~(8'd1 << r), ~pcols};
            end
            if (!r_code[4 + r]) begin
                low_cols = low_cols | pcols;
            end
        end
        pcols    = 4'd0;
        same_key = ((~r_code[3:0]) & ~low_cols) == 4'd0;
    end

    // a code decodes only with exactly one row and one column low
    always_comb begin
        drive_n = ~r_code[11:4];
        cols_n  = ~r_code[3:0];
        dec_row = 3'd0;
        dec_col = 2'd0;
        for (int r = 0; r < 8; r++) begin
            if (drive_n[r]) begin
                dec_row = 3'(r);
            end
        end
        for (int c = 0; c < 4; c++) begin
            if (cols_n[c]) begin
                dec_col = 2'(c);
            end
        end
        dec_ok = (drive_n != 8'd0) && ((drive_n & (drive_n - 8'd1)) == 8'd0)
              && (cols_n != 4'd0) && ((cols_n & (cols_n - 4'd1)) == 4'd0);
    end

    always_comb begin
        n_phase   = r_phase;
        n_code    = r_code;
        n_latched = r_latched;
        n_held    = r_held;
        n_new     = r_new;
        n_value   = '0;
        if (r_s1_func == FUNC_POLL) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (any_key) begin
                        n_code  = scan_code;
                        n_phase = PH_CONFIRM;
                    end
                end
                PH_CONFIRM: begin
                    if (same_key) begin
                        if (dec_ok) begin
                            n_latched = VALUE_BASE + VALUE_W'({dec_row, dec_col});
                            n_held    = 1'b1;
                            n_new     = 1'b1;
                        end
                        n_phase = PH_HELD;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_HELD: begin
                    if (!same_key) begin
                        n_phase = PH_GRACE;
                    end
                end
                PH_GRACE: begin
                    if (same_key) begin
                        n_phase = PH_HELD;
                    end else begin
                        n_held  = 1'b0;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end else if (r_new) begin
            n_new   = 1'b0;
            n_value = r_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_code  <= '0;
            r_latched <= '0;
            r_held  <= 1'b0;
            r_new   <= 1'b0;
        end else if (s1_adv) begin
            r_phase   <= n_phase;
            r_code    <= n_code;
            r_latched <= n_latched;
            r_held    <= n_held;
            r_new     <= n_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_func   <= i_func;
            r_s1_matrix <= i_key_matrix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_value   <= n_value;
            r_out_held    <= n_held;
            r_out_pending <= n_new;
            r_out_phase   <= n_phase;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_value;
    assign o_key_held    = r_out_held;
    assign o_key_pending = r_out_pending;
    assign o_scan_phase  = r_out_phase;

endmodule : matrix_keypad_debounce_scanner

`default_nettype wire
